### design/windowed_motion_rest_sleep_fusion_assert.svh
// Assertion helpers shared by the RTL.
// Every check is sampled on i_clk and is off while i_rst_n is low.
`ifndef WINDOWED_MOTION_REST_SLEEP_FUSION_ASSERT_SVH
`define WINDOWED_MOTION_REST_SLEEP_FUSION_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define WMRSF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define WMRSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/wmrsf_pkg.sv
package wmrsf_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 32;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);

    // Field widths
    localparam int SRC_W   = 2;
    localparam int PROB_W  = 16;
    localparam int TIME_W  = 32;
    localparam int EVENT_W = 2;
    localparam int WIN_W   = 16;
    localparam int REQ_W   = 6;
    localparam int HIT_W   = (FILL_W > REQ_W) ? FILL_W : REQ_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_COUNT  = 2'd3;

    localparam logic [PROB_W-1:0] RST_MOTION_THR = 16'd26214;
    localparam logic [PROB_W-1:0] RST_CAMERA_THR = 16'd26214;
    localparam logic [WIN_W-1:0]  RST_WIN_LEN    = 16'd5000;
    localparam logic [REQ_W-1:0]  RST_REQ_COUNT  = 6'd3;

    // Packet sources
    localparam logic [SRC_W-1:0] SRC_CAMERA = 2'd0;
    localparam logic [SRC_W-1:0] SRC_MOTION = 2'd1;

    // Reported events
    localparam logic [EVENT_W-1:0] EV_SLEEP = 2'd0;
    localparam logic [EVENT_W-1:0] EV_MOVE  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_REST  = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PROB_W-1:0] motion_thr;
        logic [PROB_W-1:0] camera_thr;
        logic [WIN_W-1:0]  win_len;
        logic [REQ_W-1:0]  req_count;
    } t_cfg;

    // One classified packet: camera check or motion update
    typedef struct packed {
        logic              is_motion;
        logic [PROB_W-1:0] prob;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] now;
    } t_op;

endpackage

### design/wmrsf_if.sv
interface wmrsf_in_if;
    logic                             valid;
    logic                             ready;
    logic [wmrsf_pkg::SRC_W-1:0]      source;
    logic [wmrsf_pkg::PROB_W-1:0]     probability;
    logic [wmrsf_pkg::TIME_W-1:0]     sample_time;
    logic [wmrsf_pkg::TIME_W-1:0]     now_ms;

    modport src  (output valid, source, probability, sample_time, now_ms, input ready);
    modport sink (input valid, source, probability, sample_time, now_ms, output ready);
endinterface

interface wmrsf_out_if;
    logic                             valid;
    logic                             ready;
    logic [wmrsf_pkg::EVENT_W-1:0]    event_res;
    logic                             camera_enable;
    logic [wmrsf_pkg::PROB_W-1:0]     report_probability;
    logic [wmrsf_pkg::TIME_W-1:0]     report_time;

    modport src  (output valid, event_res, camera_enable, report_probability, report_time,
                  input ready);
    modport sink (input valid, event_res, camera_enable, report_probability, report_time,
                  output ready);
endinterface

### design/wmrsf_front.sv
module wmrsf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wmrsf_in_if.sink          i_pkt,
    output logic              o_op_valid,
    output wmrsf_pkg::t_op    o_op,
    input  logic              i_op_ready
);

    logic           r_vld;
    wmrsf_pkg::t_op r_op;
    logic           w_take;
    logic           w_keep;

    // Take a new packet whenever the holding register is empty or drains
    assign w_take      = !r_vld || i_op_ready;
    assign i_pkt.ready = w_take;

    // Keep camera and motion packets, drop everything else
    always_comb begin
        w_keep = i_pkt.source inside {wmrsf_pkg::SRC_CAMERA, wmrsf_pkg::SRC_MOTION};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= i_pkt.valid && w_keep;
        end
    end

    // Classify and hold the payload
    always_ff @(posedge i_clk) begin
        if (w_take && i_pkt.valid) begin
            r_op.is_motion <= (i_pkt.source == wmrsf_pkg::SRC_MOTION);
            r_op.prob      <= i_pkt.probability;
            r_op.stamp     <= i_pkt.sample_time;
            r_op.now       <= i_pkt.now_ms;
        end
    end

    assign o_op_valid = r_vld;
    assign o_op       = r_op;

endmodule

### design/wmrsf_queue.sv
module wmrsf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  wmrsf_pkg::t_op    i_data,
    output logic              o_pop_valid,
    input  logic              i_pop,
    output wmrsf_pkg::t_op    o_data
);

    wmrsf_pkg::t_op                      r_mem [wmrsf_pkg::QUEUE_DEPTH];
    logic [wmrsf_pkg::QUEUE_AW-1:0]      r_wr;
    logic [wmrsf_pkg::QUEUE_AW-1:0]      r_rd;
    logic [wmrsf_pkg::QUEUE_CW-1:0]      r_cnt;
    logic                                w_push;
    logic                                w_pop;

    assign o_push_ready = (r_cnt != wmrsf_pkg::QUEUE_CW'(wmrsf_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;
    assign o_data       = r_mem[r_rd];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == wmrsf_pkg::QUEUE_AW'(wmrsf_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == wmrsf_pkg::QUEUE_AW'(wmrsf_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### design/wmrsf_back.sv
`include "windowed_motion_rest_sleep_fusion_assert.svh"

module wmrsf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wmrsf_pkg::t_cfg   i_cfg,
    input  logic              i_op_valid,
    output logic              o_op_pop,
    input  wmrsf_pkg::t_op    i_op,
    wmrsf_out_if.src          o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // Ring storage
    logic [wmrsf_pkg::PROB_W-1:0]  r_prob_ring [wmrsf_pkg::RING_DEPTH];
    logic [wmrsf_pkg::TIME_W-1:0]  r_time_ring [wmrsf_pkg::RING_DEPTH];
    logic [wmrsf_pkg::PROB_W-1:0]  r_prob_q;
    logic [wmrsf_pkg::TIME_W-1:0]  r_time_q;

    // Control state
    logic [1:0]                    r_state, n_state;
    logic [wmrsf_pkg::RING_AW-1:0] r_head, n_head;
    logic [wmrsf_pkg::FILL_W-1:0]  r_fill, n_fill;
    logic                          r_resting, n_resting;
    logic [wmrsf_pkg::FILL_W-1:0]  r_idx, n_idx;
    logic [wmrsf_pkg::HIT_W-1:0]   r_hits, n_hits;
    logic                          r_rd_vld, n_rd_vld;
    logic [wmrsf_pkg::RING_AW-1:0] r_rd_addr, n_rd_addr;
    logic                          r_out_valid, n_out_valid;

    // Payload state
    wmrsf_pkg::t_op                r_cur, n_cur;
    logic [wmrsf_pkg::EVENT_W-1:0] r_res_event, n_res_event;
    logic                          r_res_cam, n_res_cam;
    logic [wmrsf_pkg::EVENT_W-1:0] r_out_event;
    logic                          r_out_cam;
    logic [wmrsf_pkg::PROB_W-1:0]  r_out_prob;
    logic [wmrsf_pkg::TIME_W-1:0]  r_out_time;

    logic                          w_out_free;
    logic                          w_load;
    logic                          w_pop;
    logic                          w_write;
    logic                          w_issue;
    logic [wmrsf_pkg::TIME_W-1:0]  w_age;
    logic                          w_in_win;
    logic                          w_hit;
    logic [wmrsf_pkg::HIT_W-1:0]   w_hits_inc;
    logic                          w_found;
    logic                          w_stop;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_load     = (r_state == ST_EMIT) && w_out_free;
    assign w_pop      = (r_state == ST_IDLE) && i_op_valid;
    assign w_write    = w_pop && i_op.is_motion;
    assign o_op_pop   = w_pop;

    // Scan datapath: one entry read per cycle, evaluated the cycle after
    assign w_issue    = (r_state == ST_SCAN) && (r_idx != r_fill);
    assign w_age      = r_cur.now - r_time_q;
    assign w_in_win   = (w_age <= wmrsf_pkg::TIME_W'(i_cfg.win_len));
    assign w_hit      = (r_prob_q >= i_cfg.motion_thr);
    assign w_hits_inc = r_hits + 1'b1;
    assign w_found    = (r_state == ST_SCAN) && r_rd_vld && w_in_win && w_hit &&
                        (w_hits_inc >= wmrsf_pkg::HIT_W'(i_cfg.req_count));
    assign w_stop     = (r_state == ST_SCAN) &&
                        ((r_rd_vld && !w_in_win) || (!r_rd_vld && (r_idx == r_fill)));

    // Sequence one operation at a time
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_resting   = r_resting;
        n_idx       = r_idx;
        n_hits      = r_hits;
        n_rd_vld    = r_rd_vld;
        n_rd_addr   = r_rd_addr;
        n_cur       = r_cur;
        n_res_event = r_res_event;
        n_res_cam   = r_res_cam;
        n_out_valid = w_load ? 1'b1 : (o_res.ready ? 1'b0 : r_out_valid);

        case (r_state)
            ST_IDLE: begin
                if (i_op_valid) begin
                    n_cur = i_op;
                    if (i_op.is_motion) begin
                        n_head    = (r_head == wmrsf_pkg::RING_AW'(wmrsf_pkg::RING_DEPTH - 1)) ?
                                    '0 : r_head + 1'b1;
                        if (r_fill != wmrsf_pkg::FILL_W'(wmrsf_pkg::RING_DEPTH)) begin
                            n_fill = r_fill + 1'b1;
                        end
                        n_idx     = '0;
                        n_hits    = '0;
                        n_rd_vld  = 1'b0;
                        n_rd_addr = r_head;
                        n_state   = ST_SCAN;
                    end else if (r_resting && (i_op.prob > i_cfg.camera_thr)) begin
                        n_res_event = wmrsf_pkg::EV_SLEEP;
                        n_res_cam   = 1'b1;
                        n_state     = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                n_rd_vld = w_issue;
                if (w_issue) begin
                    n_idx     = r_idx + 1'b1;
                    n_rd_addr = (r_rd_addr == '0) ?
                                wmrsf_pkg::RING_AW'(wmrsf_pkg::RING_DEPTH - 1) :
                                r_rd_addr - 1'b1;
                end
                if (r_rd_vld && w_in_win && w_hit) begin
                    n_hits = w_hits_inc;
                end
                if (w_found) begin
                    n_resting   = 1'b0;
                    n_res_event = wmrsf_pkg::EV_MOVE;
                    n_res_cam   = 1'b0;
                    n_state     = ST_EMIT;
                end else if (w_stop) begin
                    n_resting   = 1'b1;
                    n_res_event = wmrsf_pkg::EV_REST;
                    n_res_cam   = 1'b1;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_resting   <= 1'b0;
            r_idx       <= '0;
            r_hits      <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_addr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_resting   <= n_resting;
            r_idx       <= n_idx;
            r_hits      <= n_hits;
            r_rd_vld    <= n_rd_vld;
            r_rd_addr   <= n_rd_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the current operation, its result and the output register
    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_res_event <= n_res_event;
        r_res_cam   <= n_res_cam;
        if (w_load) begin
            r_out_event <= r_res_event;
            r_out_cam   <= r_res_cam;
            r_out_prob  <= r_cur.prob;
            r_out_time  <= r_cur.stamp;
        end
    end

    // Ring memory: write the new motion entry, read one entry per scan cycle
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_prob_ring[r_head] <= i_op.prob;
            r_time_ring[r_head] <= i_op.stamp;
        end
        if (w_issue) begin
            r_prob_q <= r_prob_ring[r_rd_addr];
            r_time_q <= r_time_ring[r_rd_addr];
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.event_res          = r_out_event;
    assign o_res.camera_enable      = r_out_cam;
    assign o_res.report_probability = r_out_prob;
    assign o_res.report_time        = r_out_time;

    `WMRSF_ASSERT_SAME(a_fill_bound, 1'b1,
        r_fill <= wmrsf_pkg::FILL_W'(wmrsf_pkg::RING_DEPTH), "ring fill above depth")
    `WMRSF_ASSERT_SAME(a_scan_nonempty, r_state == ST_SCAN,
        (r_fill != '0) && (r_idx <= r_fill), "scan with empty ring or index past fill")
    `WMRSF_ASSERT_NEXT(a_move_clears_rest, w_found, !r_resting && (r_res_cam == 1'b0),
        "movement did not clear resting")
    `WMRSF_ASSERT_NEXT(a_load_sets_valid, w_load, r_out_valid && (r_state == ST_IDLE),
        "result load did not set output valid")
    `WMRSF_ASSERT_SAME(a_pop_only_idle, o_op_pop, r_state == ST_IDLE,
        "queue popped outside idle")

endmodule

### design/windowed_motion_rest_sleep_fusion.sv
// Channel   Direction  Payload                                           Accepted when
// i_pkt     in         source, probability, sample_time, now_ms          valid && ready
// o_res     out        event_res, camera_enable, report_probability,
//                      report_time                                       valid && ready
// i_cfg_*   in         register index, write data                        i_cfg_we
//
// Heart-rate packets vanish in the front stage. A motion packet runs a backward scan that
// reads one ring entry per cycle from a single port. The scan ends early on the first entry
// outside the window or once enough movement hits are counted. Reset is synchronous and
// active low; it empties the ring and clears resting. The input stays open while the back
// end scans or a result waits, until the two-entry queue and the front register are full.
module windowed_motion_rest_sleep_fusion (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wmrsf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wmrsf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    wmrsf_in_if.sink                            i_pkt,
    wmrsf_out_if.src                            o_res
);

    wmrsf_pkg::t_cfg r_cfg;
    logic            w_f_valid;
    logic            w_f_ready;
    wmrsf_pkg::t_op  w_f_op;
    logic            w_b_valid;
    logic            w_b_pop;
    wmrsf_pkg::t_op  w_b_op;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motion_thr <= wmrsf_pkg::RST_MOTION_THR;
            r_cfg.camera_thr <= wmrsf_pkg::RST_CAMERA_THR;
            r_cfg.win_len    <= wmrsf_pkg::RST_WIN_LEN;
            r_cfg.req_count  <= wmrsf_pkg::RST_REQ_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wmrsf_pkg::CFG_MOTION_THR: r_cfg.motion_thr <= i_cfg_data;
                wmrsf_pkg::CFG_CAMERA_THR: r_cfg.camera_thr <= i_cfg_data;
                wmrsf_pkg::CFG_WIN_LEN:    r_cfg.win_len    <= i_cfg_data;
                wmrsf_pkg::CFG_REQ_COUNT:  r_cfg.req_count  <= i_cfg_data[wmrsf_pkg::REQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wmrsf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (i_pkt),
        .o_op_valid (w_f_valid),
        .o_op       (w_f_op),
        .i_op_ready (w_f_ready)
    );

    wmrsf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_data       (w_f_op),
        .o_pop_valid  (w_b_valid),
        .i_pop        (w_b_pop),
        .o_data       (w_b_op)
    );

    wmrsf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_op_valid (w_b_valid),
        .o_op_pop   (w_b_pop),
        .i_op       (w_b_op),
        .o_res      (o_res)
    );

endmodule

### verif/wmrsf_checker.sv
module wmrsf_checker
    import wmrsf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    wmrsf_in_if                   i_pkt,
    wmrsf_out_if                  i_res,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic               camera_on;
        logic [PROB_W-1:0]  prob;
        logic [TIME_W-1:0]  stamp;
    } t_report;

    // Shadow of the fusion state and its settings
    t_cfg              cfg_now;
    logic [PROB_W-1:0] prob_hist [RING_DEPTH];
    logic [TIME_W-1:0] time_hist [RING_DEPTH];
    int                hist_head;
    int                hist_fill;
    logic              rest_flag;

    t_report           expected_reports [$];
    int                mismatch_count = 0;

    assign o_errors = mismatch_count;

    // Walk back from the newest motion entry; stop at the first one outside the window
    function automatic bit window_has_motion(input logic [TIME_W-1:0] now_t);
        int                hits;
        int                slot;
        logic [TIME_W-1:0] age;
        hits = 0;
        for (int k = 0; k < hist_fill; k++) begin
            slot = (hist_head + RING_DEPTH - 1 - k) % RING_DEPTH;
            age  = now_t - time_hist[slot];
            if (age > TIME_W'(cfg_now.win_len)) return 1'b0;
            if (prob_hist[slot] >= cfg_now.motion_thr) begin
                hits++;
                if (hits >= int'(cfg_now.req_count)) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advance the shadow state by one packet and queue the report it causes
    task automatic predict_fusion(input logic [SRC_W-1:0] src, input logic [PROB_W-1:0] prob,
                                  input logic [TIME_W-1:0] stamp,
                                  input logic [TIME_W-1:0] now_t);
        t_report rep;
        if (src == SRC_CAMERA) begin
            if (rest_flag && prob > cfg_now.camera_thr) begin
                rep = '{EV_SLEEP, 1'b1, prob, stamp};
                expected_reports.push_back(rep);
            end
        end else if (src == SRC_MOTION) begin
            prob_hist[hist_head] = prob;
            time_hist[hist_head] = stamp;
            hist_head = (hist_head + 1) % RING_DEPTH;
            if (hist_fill < RING_DEPTH) hist_fill++;
            rest_flag = !window_has_motion(now_t);
            rep = '{rest_flag ? EV_REST : EV_MOVE, rest_flag, prob, stamp};
            expected_reports.push_back(rep);
        end
    endtask

    function automatic int diff_field(input string what, input logic [TIME_W-1:0] want,
                                      input logic [TIME_W-1:0] got);
        if (got === want) return 0;
        $display("%0d ns wmrsf_checker: %s expected 0x%0h actual 0x%0h",
                 $time, what, want, got);
        return 1;
    endfunction

    // Track settings, score results, then predict from the accepted packet
    always @(posedge i_clk) begin
        t_report want;
        if (!i_rst_n) begin
            cfg_now   = '{RST_MOTION_THR, RST_CAMERA_THR, RST_WIN_LEN, RST_REQ_COUNT};
            hist_head = 0;
            hist_fill = 0;
            rest_flag = 1'b0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MOTION_THR: cfg_now.motion_thr = i_cfg_data;
                    CFG_CAMERA_THR: cfg_now.camera_thr = i_cfg_data;
                    CFG_WIN_LEN:    cfg_now.win_len    = i_cfg_data;
                    CFG_REQ_COUNT:  cfg_now.req_count  = i_cfg_data[REQ_W-1:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0d ns wmrsf_checker: result expected none actual ev %0d cam %0d",
                             $time, i_res.event_res, i_res.camera_enable);
                    mismatch_count++;
                end else begin
                    want = expected_reports.pop_front();
                    mismatch_count += diff_field("event_res", TIME_W'(want.event_res),
                                                 TIME_W'(i_res.event_res));
                    mismatch_count += diff_field("camera_enable", TIME_W'(want.camera_on),
                                                 TIME_W'(i_res.camera_enable));
                    mismatch_count += diff_field("report_probability", TIME_W'(want.prob),
                                                 TIME_W'(i_res.report_probability));
                    mismatch_count += diff_field("report_time", want.stamp, i_res.report_time);
                end
            end
            if (i_pkt.valid && i_pkt.ready) begin
                predict_fusion(i_pkt.source, i_pkt.probability, i_pkt.sample_time,
                               i_pkt.now_ms);
            end
        end
        o_pending <= expected_reports.size();
    end

endmodule

### verif/tb_top.sv
module tb_top
    import wmrsf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SRC_W-1:0] SRC_HEART  = 2'd2;
    localparam logic [SRC_W-1:0] SRC_UNUSED = 2'd3;

    localparam int LIMIT_CYCLES    = 400_000;
    localparam int DRAIN_CYCLES    = 48;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    errors;
    int                    pending;
    int                    cycles;

    // Stimulus state
    logic [TIME_W-1:0]     wall_ms;
    logic [PROB_W-1:0]     cur_mthr;
    logic [PROB_W-1:0]     cur_cthr;
    logic [WIN_W-1:0]      cur_win;
    bit                    steady_run   = 1'b0;
    bit                    hold_off_req = 1'b0;

    wmrsf_in_if  pkt_ch ();
    wmrsf_out_if res_ch ();

    windowed_motion_rest_sleep_fusion DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pkt      (pkt_ch),
        .o_res      (res_ch)
    );

    wmrsf_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pkt      (pkt_ch),
        .i_res      (res_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap(input bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Pick a probability at the edges of the range, right around a threshold, or at random
    function automatic logic [PROB_W-1:0] near_level(input logic [PROB_W-1:0] level);
        logic [PROB_W-1:0] lvl;
        lvl = (level > 16'd32768) ? 16'd32768 : level;
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd32768;
            2: return (lvl == 16'd0) ? 16'd0 : lvl - 16'd1;
            3: return lvl;
            4: return (lvl == 16'd32768) ? lvl : lvl + 16'd1;
            default: return PROB_W'($urandom_range(0, 32768));
        endcase
    endfunction

    // Offer one packet and hold it until the transaction completes
    task automatic send_pkt(input logic [SRC_W-1:0] src, input logic [PROB_W-1:0] prob,
                            input logic [TIME_W-1:0] stamp, input logic [TIME_W-1:0] now_t);
        int gap;
        gap = idle_gap(steady_run);
        if (gap > 0) begin
            pkt_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pkt_ch.valid       <= 1'b1;
        pkt_ch.source      <= src;
        pkt_ch.probability <= prob;
        pkt_ch.sample_time <= stamp;
        pkt_ch.now_ms      <= now_t;
        do @(posedge i_clk); while (!pkt_ch.ready);
    endtask

    // Stop offering, wait for every outstanding result, then let the scan settle
    task automatic drain_results();
        pkt_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back; call only while idle
    task automatic load_settings(input logic [PROB_W-1:0] m_thr, input logic [PROB_W-1:0] c_thr,
                                 input logic [WIN_W-1:0] win, input logic [REQ_W-1:0] req);
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_MOTION_THR, CFG_CAMERA_THR, CFG_WIN_LEN, CFG_REQ_COUNT};
        vals = '{m_thr, c_thr, win, CFG_DATA_W'(req)};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_mthr = m_thr;
        cur_cthr = c_thr;
        cur_win  = win;
    endtask

    // Random packets: mostly motion with stamps inside or just past the window
    task automatic run_phase(input int count);
        int                sent;
        int                roll;
        int                step_max;
        logic [SRC_W-1:0]  src;
        logic [PROB_W-1:0] prob;
        logic [TIME_W-1:0] stamp;
        sent     = 0;
        step_max = int'(cur_win) / 6 + 1;
        while (sent < count) begin
            wall_ms = wall_ms + TIME_W'($urandom_range(0, step_max));
            roll = $urandom_range(0, 99);
            if (roll < 55)      src = SRC_MOTION;
            else if (roll < 88) src = SRC_CAMERA;
            else if (roll < 95) src = SRC_HEART;
            else                src = SRC_UNUSED;
            prob = (src == SRC_CAMERA) ? near_level(cur_cthr) : near_level(cur_mthr);
            roll = $urandom_range(0, 99);
            if (roll < 80)      stamp = wall_ms - $urandom_range(0, int'(cur_win) + 8);
            else if (roll < 90) stamp = wall_ms + $urandom_range(1, 1000);
            else                stamp = $urandom();
            send_pkt(src, prob, stamp, wall_ms);
            if (src == SRC_CAMERA || src == SRC_MOTION) sent++;
            if ($urandom_range(0, 39) == 0) drain_results();
        end
    endtask

    // Result side: random stalls, free-running stretches, and one long hold-off on request
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(40, 120)) @(posedge i_clk);
            end else begin
                gap = idle_gap(1'b0);
                if (gap > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Watchdog
    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_MOTION_THR;
        i_cfg_data         = '0;
        pkt_ch.valid       = 1'b0;
        pkt_ch.source      = SRC_CAMERA;
        pkt_ch.probability = '0;
        pkt_ch.sample_time = '0;
        pkt_ch.now_ms      = '0;
        cur_mthr           = RST_MOTION_THR;
        cur_cthr           = RST_CAMERA_THR;
        cur_win            = RST_WIN_LEN;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed checks at the reset settings
        wall_ms = 32'd10_000;
        send_pkt(SRC_CAMERA, 16'd32768, 32'd9_990, wall_ms);      // not resting yet
        send_pkt(SRC_HEART, 16'd32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pkt(SRC_UNUSED, 16'd0, 32'd0, 32'd0);
        send_pkt(SRC_MOTION, 16'd32768, 32'd10_000, 32'd10_000);  // fewer entries than needed
        send_pkt(SRC_CAMERA, 16'd26214, 32'd0, 32'd10_500);       // equal to threshold
        send_pkt(SRC_CAMERA, 16'd26215, 32'd10_600, 32'd10_600);
        send_pkt(SRC_CAMERA, 16'd32768, 32'hFFFF_FFFF, 32'd10_700);
        send_pkt(SRC_MOTION, 16'd26214, 32'd11_000, 32'd11_000);  // motion level exactly
        send_pkt(SRC_MOTION, 16'd0, 32'd12_000, 32'd12_000);
        send_pkt(SRC_MOTION, 16'd32768, 32'd13_000, 32'd13_000);  // third hit: movement
        send_pkt(SRC_CAMERA, 16'd32768, 32'd13_100, 32'd13_100);  // not resting
        send_pkt(SRC_MOTION, 16'd32768, 32'd20_000, 32'd13_000);  // stamp ahead of now
        send_pkt(SRC_MOTION, 16'd32768, 32'd18_000, 32'd23_000);  // age equals window
        send_pkt(SRC_MOTION, 16'd32768, 32'd22_999, 32'd28_000);  // age one past window
        send_pkt(SRC_MOTION, 16'd32768, 32'hFFFF_FFFF, 32'd10);   // age wraps through zero
        send_pkt(SRC_MOTION, 16'd32768, 32'd0, 32'd10);
        drain_results();

        // Random phases over a spread of settings
        wall_ms = $urandom();
        run_phase(60);
        drain_results();

        // Lowest values: every entry counts, a zero count acts as one, zero-length window
        load_settings(16'd0, 16'd0, 16'd0, 6'd0);
        wall_ms = $urandom();
        run_phase(40);
        drain_results();

        load_settings(16'd32768, 16'd32768, 16'd65535, 6'd32);
        wall_ms = $urandom();
        run_phase(40);
        drain_results();

        // Full ring with every entry a hit
        load_settings(16'd0, 16'd32768, 16'd65535, 6'd32);
        wall_ms = $urandom();
        run_phase(50);
        drain_results();

        // Raw register bits past the documented range
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63);
        wall_ms = $urandom();
        run_phase(30);
        drain_results();

        // Hold off the result side while packets keep coming; the clock wraps here
        load_settings(16'd16384, 16'd8000, 16'd1000, 6'd1);
        wall_ms      = 32'hFFFF_FC00;
        hold_off_req = 1'b1;
        steady_run   = 1'b1;
        run_phase(25);
        steady_run   = 1'b0;
        run_phase(35);
        drain_results();

        load_settings(PROB_W'($urandom_range(0, 32768)), PROB_W'($urandom_range(0, 32768)),
                      WIN_W'($urandom_range(0, 3000)), REQ_W'($urandom_range(1, 32)));
        wall_ms = $urandom();
        run_phase(50);
        drain_results();

        load_settings(PROB_W'($urandom_range(0, 32768)), PROB_W'($urandom_range(0, 32768)),
                      WIN_W'($urandom_range(0, 65535)), REQ_W'($urandom_range(1, 8)));
        wall_ms = $urandom();
        run_phase(50);
        drain_results();

        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
